/* hw/rtl/oaht_pkg.sv */
// Shared types, codes and helper functions for the open-address hash table.
// No dependencies; the table, the hash unit and the testbench import this package.
package oaht_pkg;

  localparam int KEY_BITS  = 64;
  localparam int VAL_PORT  = 64;
  localparam int SLOT_BITS = 10;
  localparam int CNT_BITS  = 11;

  typedef enum logic [1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_FOUND = 3'd0,
    ST_NEW   = 3'd1,
    ST_REINS = 3'd2,
    ST_MISS  = 3'd3,
    ST_FULL  = 3'd4
  } status_t;

  // Bucket marks: bit 1 means empty, bit 0 means deleted, both clear is live.
  localparam logic [1:0] MARK_LIVE  = 2'b00;
  localparam logic [1:0] MARK_DEL   = 2'b01;
  localparam logic [1:0] MARK_EMPTY = 2'b10;

  localparam logic [1:0] KM_MIX64 = 2'd0;
  localparam logic [1:0] KM_ID32  = 2'd1;
  localparam logic [1:0] KM_ID16  = 2'd2;

  localparam logic CFG_STORE_VALUES = 1'b0;
  localparam logic CFG_KEY_MODE     = 1'b1;

  // Keeps only the key bits that take part in hashing and comparison.
  function automatic logic [KEY_BITS-1:0] key_bits(input logic [KEY_BITS-1:0] k,
                                                   input logic [1:0] mode);
    logic [KEY_BITS-1:0] r;
    case (mode)
      KM_ID32: r = {32'b0, k[31:0]};
      KM_ID16: r = {48'b0, k[15:0]};
      default: r = k;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/open_address_hash_table.sv */
// Open-address hash table with triangular probing, one bucket memory.
// Probing: a lookup, insert or delete reads one probe per cycle, set by the single read port of the
// bucket RAM; a clear writes one entry per cycle.
// Throughput: one transaction at a time; busy is high from accept until the result strobe.
// Reset: synchronous active-high rst; after reset a sweep marks every bucket empty while busy
// is high. Results are strobed by done for one cycle; the receiver cannot stall.
module open_address_hash_table #(
  parameter int BUCKETS    = 1024,
  parameter int VALUE_BITS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     req_type,
  input  logic [oaht_pkg::KEY_BITS-1:0]  key,
  input  logic [oaht_pkg::VAL_PORT-1:0]  value_in,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [1:0]                     cfg_data,
  output logic                           done,
  output logic [2:0]                     status,
  output logic [oaht_pkg::SLOT_BITS-1:0] slot,
  output logic [oaht_pkg::VAL_PORT-1:0]  value_out,
  output logic [oaht_pkg::CNT_BITS-1:0]  live_count
);
  import oaht_pkg::*;

  localparam int IW = $clog2(BUCKETS);
  localparam int CW = $clog2(BUCKETS + 1);
  localparam int EW = 2 + KEY_BITS + VALUE_BITS;

  // One-hot controller states.
  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_PROBE  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state;

  // Configuration registers.
  logic       store_values;
  logic [1:0] key_mode;

  // Latched request.
  logic [1:0]            req;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;

  // Probe state: current bucket, probe number, last deleted bucket passed.
  logic [IW-1:0] idx;
  logic [IW-1:0] n;
  logic [IW-1:0] site;
  logic          has_site;
  logic [IW-1:0] pos;
  logic          pr_empty;
  logic          pr_match;
  logic [EW-1:0] hit_data;

  logic [IW-1:0] clr_idx;
  logic          clr_report;
  logic [CW-1:0] live_keys;

  // RAM interface.
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  logic [IW-1:0] home;
  logic [IW-1:0] idx_adv;

  oaht_hash #(.IW(IW)) u_hash (
    .key      (key),
    .key_mode (key_mode),
    .home     (home)
  );

  oaht_ram #(.WIDTH(EW), .DEPTH(BUCKETS)) u_buckets (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Fields of the bucket that the RAM returned this cycle.
  logic [1:0]            rd_mark;
  logic [KEY_BITS-1:0]   rd_key;
  logic                  rd_empty;
  logic                  rd_del;
  logic                  rd_match;

  assign rd_mark  = ram_rdata[EW-1 -: 2];
  assign rd_key   = ram_rdata[VALUE_BITS +: KEY_BITS];
  assign rd_empty = rd_mark[1];
  assign rd_del   = rd_mark[0];
  assign rd_match = !rd_empty && !rd_del &&
                    (key_bits(rd_key, key_mode) == key_bits(key_r, key_mode));

  // Triangular step: after probe n the index advances by n + 1.
  assign idx_adv = idx + n + IW'(1);

  // Fields of the bucket held from the final probe.
  logic [KEY_BITS-1:0]   hit_key;
  logic [VALUE_BITS-1:0] hit_val;
  assign hit_key = hit_data[VALUE_BITS +: KEY_BITS];
  assign hit_val = hit_data[VALUE_BITS-1:0];

  logic [VALUE_BITS-1:0] new_val;
  assign new_val = store_values ? val_r : '0;

  // Final-step decisions: result fields, write-back and count update.
  logic [2:0]            fin_status;
  logic [IW-1:0]         fin_slot;
  logic [VALUE_BITS-1:0] fin_val;
  logic [CW-1:0]         live_next;

  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = pos;
    ram_wdata  = hit_data;
    ram_raddr  = idx_adv;
    fin_status = ST_MISS;
    fin_slot   = '0;
    fin_val    = '0;
    live_next  = live_keys;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx;
        ram_wdata = {MARK_EMPTY, {(EW-2){1'b0}}};
      end
      S_IDLE: begin
        ram_raddr = home;
      end
      S_FINISH: begin
        case (req)
          REQ_LOOKUP: begin
            if (pr_match) begin
              fin_status = ST_FOUND;
              fin_slot   = pos;
              fin_val    = store_values ? hit_val : '0;
            end
          end
          REQ_DELETE: begin
            if (pr_match) begin
              ram_we     = 1'b1;
              ram_wdata  = {MARK_DEL, hit_key, hit_val};
              fin_status = ST_FOUND;
              fin_slot   = pos;
              if (live_keys != '0) begin
                live_next = live_keys - CW'(1);
              end
            end
          end
          REQ_INSERT: begin
            if (pr_match) begin
              // Present key: only the value may change.
              ram_we     = store_values;
              ram_wdata  = {MARK_LIVE, hit_key, val_r};
              fin_status = ST_FOUND;
              fin_slot   = pos;
            end else if (has_site) begin
              ram_we     = 1'b1;
              ram_waddr  = site;
              ram_wdata  = {MARK_LIVE, key_r, new_val};
              fin_status = ST_REINS;
              fin_slot   = site;
              live_next  = live_keys + CW'(1);
            end else if (pr_empty) begin
              ram_we     = 1'b1;
              ram_wdata  = {MARK_LIVE, key_r, new_val};
              fin_status = ST_NEW;
              fin_slot   = pos;
              live_next  = live_keys + CW'(1);
            end else begin
              fin_status = ST_FULL;
            end
          end
          default: begin
            fin_status = ST_MISS;
          end
        endcase
      end
      default: begin
        ram_raddr = idx_adv;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

  // Configuration writes are taken at any edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      store_values <= 1'b1;
      key_mode     <= KM_MIX64;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STORE_VALUES: store_values <= cfg_data[0];
        CFG_KEY_MODE:     key_mode     <= cfg_data;
        default:          key_mode     <= key_mode;
      endcase
    end
  end

  // Widened copies for the fixed-width result ports.
  logic [IW+SLOT_BITS-1:0]          slot_wide;
  logic [VALUE_BITS+VAL_PORT-1:0]   val_wide;
  logic [CW+CNT_BITS-1:0]           cnt_wide;
  assign slot_wide = {{SLOT_BITS{1'b0}}, fin_slot};
  assign val_wide  = {{VAL_PORT{1'b0}}, fin_val};

  always_comb begin
    if (state == S_CLEAR) begin
      cnt_wide = '0;
    end else begin
      cnt_wide = {{CNT_BITS{1'b0}}, live_next};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      clr_report <= 1'b0;
      live_keys  <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + IW'(1);
          if (clr_idx == IW'(BUCKETS - 1)) begin
            state     <= S_IDLE;
            live_keys <= '0;
            if (clr_report) begin
              // A clear request reports found with zero slot, value and count.
              done       <= 1'b1;
              status     <= ST_FOUND;
              slot       <= '0;
              value_out  <= '0;
              live_count <= cnt_wide[CNT_BITS-1:0];
            end
          end
        end
        S_IDLE: begin
          if (start) begin
            req   <= req_type;
            key_r <= key;
            val_r <= value_in[VALUE_BITS-1:0];
            if (req_type == REQ_CLEAR) begin
              state      <= S_CLEAR;
              clr_idx    <= '0;
              clr_report <= 1'b1;
            end else begin
              // The home bucket read is already issued this cycle.
              state    <= S_PROBE;
              idx      <= home;
              n        <= '0;
              has_site <= 1'b0;
              site     <= '0;
            end
          end
        end
        S_PROBE: begin
          // The read for bucket idx returns now; the next read goes out in parallel.
          idx      <= idx_adv;
          n        <= n + IW'(1);
          pos      <= idx;
          hit_data <= ram_rdata;
          pr_empty <= rd_empty;
          pr_match <= rd_match;
          if (!rd_empty && !rd_match && rd_del) begin
            site     <= idx;
            has_site <= 1'b1;
          end
          if (rd_empty || rd_match || n == IW'(BUCKETS - 1)) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          state      <= S_IDLE;
          live_keys  <= live_next;
          done       <= 1'b1;
          status     <= fin_status;
          slot       <= slot_wide[SLOT_BITS-1:0];
          value_out  <= val_wide[VAL_PORT-1:0];
          live_count <= cnt_wide[CNT_BITS-1:0];
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/oaht_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module oaht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/oaht_hash.sv */
// Home bucket computation: identity or 64-bit shift-xor mix of the key.
// Depends on oaht_pkg.
module oaht_hash #(
  parameter int IW = 10
) (
  input  logic [oaht_pkg::KEY_BITS-1:0] key,
  input  logic [1:0]                    key_mode,
  output logic [IW-1:0]                 home
);
  import oaht_pkg::*;

  logic [KEY_BITS-1:0] h;

  always_comb begin
    if (key_mode == KM_ID32 || key_mode == KM_ID16) begin
      h = key_bits(key, key_mode);
    end else begin
      h = (key >> 33) ^ key ^ (key << 11);
    end
  end

  assign home = h[IW-1:0];

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for open_address_hash_table: directed and random
// transactions, a predictor of the bucket table, and a result checker.
// Depends on oaht_pkg and the open_address_hash_table RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import oaht_pkg::*;

  localparam int NBKT     = 1024;
  localparam int WATCHDOG = 6000;
  localparam int POOL_N   = 48;

  typedef struct {
    req_t        req;
    logic [63:0] key;
    logic [63:0] val;
  } request_t;

  typedef struct {
    status_t     status;
    logic [9:0]  slot;
    logic [63:0] value;
    logic [10:0] count;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  req_type = '0;
  logic [63:0] key = '0;
  logic [63:0] value_in = '0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [1:0]  cfg_data = '0;
  logic        busy, done;
  logic [2:0]  status;
  logic [9:0]  slot;
  logic [63:0] value_out;
  logic [10:0] live_count;

  open_address_hash_table dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .key(key), .value_in(value_in),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .status(status), .slot(slot),
    .value_out(value_out), .live_count(live_count)
  );

  always #10 clk = ~clk;

  // Predictor state: a private copy of the bucket table and the registers.
  logic [1:0]  tbl_marks [NBKT];
  logic [63:0] tbl_keys [NBKT];
  logic [63:0] tbl_vals [NBKT];
  int unsigned live_n, used_n;
  logic        cur_store = 1'b1;
  logic [1:0]  cur_mode = KM_MIX64;

  request_t    pending_reqs[$];
  answer_t     expected_answers[$];
  int unsigned issued = 0, queued = 0, errors = 0;
  bit          allow_idle = 1'b1;
  logic [63:0] key_pool [POOL_N];

  initial begin
    for (int i = 0; i < NBKT; i++) tbl_marks[i] = MARK_EMPTY;
    live_n = 0;
    used_n = 0;
  end

  // Only the bits selected by the key mode take part; mode three acts as mode zero.
  function automatic logic [63:0] cmp_bits(logic [63:0] k);
    if (cur_mode == KM_ID32) return {32'b0, k[31:0]};
    if (cur_mode == KM_ID16) return {48'b0, k[15:0]};
    return k;
  endfunction

  function automatic int unsigned home_bucket(logic [63:0] k);
    logic [63:0] h;
    if (cur_mode == KM_ID32 || cur_mode == KM_ID16) h = cmp_bits(k);
    else h = (k >> 33) ^ k ^ (k << 11);
    return h[9:0];
  endfunction

  // Walks the triangular probe sequence and applies the request to the table.
  function automatic answer_t apply_request(request_t r);
    answer_t     a;
    int unsigned idx, hit_pos, site;
    bit          hit, empty_hit, has_site;
    a.status = ST_MISS;
    a.slot = '0;
    a.value = '0;
    hit = 0;
    empty_hit = 0;
    has_site = 0;
    hit_pos = 0;
    site = 0;
    if (r.req == REQ_CLEAR) begin
      for (int i = 0; i < NBKT; i++) tbl_marks[i] = MARK_EMPTY;
      live_n = 0;
      used_n = 0;
      a.status = ST_FOUND;
    end else begin
      idx = home_bucket(r.key);
      for (int n = 0; n < NBKT; n++) begin
        if (tbl_marks[idx][1]) begin
          empty_hit = 1;
          hit_pos = idx;
          break;
        end
        if (!tbl_marks[idx][0] && cmp_bits(tbl_keys[idx]) == cmp_bits(r.key)) begin
          hit = 1;
          hit_pos = idx;
          break;
        end
        if (tbl_marks[idx][0]) begin
          site = idx;
          has_site = 1;
        end
        idx = (idx + n + 1) % NBKT;
      end
      case (r.req)
        REQ_LOOKUP: if (hit) begin
          a.status = ST_FOUND;
          a.slot = hit_pos[9:0];
          if (cur_store) a.value = tbl_vals[hit_pos];
        end
        REQ_DELETE: if (hit) begin
          tbl_marks[hit_pos] = MARK_DEL;
          if (live_n > 0) live_n--;
          a.status = ST_FOUND;
          a.slot = hit_pos[9:0];
        end
        default: begin
          if (hit) begin
            a.status = ST_FOUND;
            a.slot = hit_pos[9:0];
            if (cur_store) tbl_vals[hit_pos] = r.val;
          end else if (has_site || empty_hit) begin
            // A passed deleted bucket wins over the empty one that ended the walk.
            if (has_site) hit_pos = site;
            tbl_keys[hit_pos] = r.key;
            tbl_vals[hit_pos] = cur_store ? r.val : 64'd0;
            tbl_marks[hit_pos] = MARK_LIVE;
            live_n++;
            if (!has_site) used_n++;
            a.status = has_site ? ST_REINS : ST_NEW;
            a.slot = hit_pos[9:0];
          end else begin
            a.status = ST_FULL;
          end
        end
      endcase
    end
    a.count = live_n[10:0];
    return a;
  endfunction

  // Driver: start stays high with stable fields until the transaction is taken.
  always @(posedge clk) begin
    request_t nxt;
    bit       taken;
    if (!rst) begin
      taken = start && !busy;
      if (taken) expected_answers.push_back(apply_request('{req_t'(req_type), key, value_in}));
      if (!start || taken) begin
        if (pending_reqs.size() > 0 && !(allow_idle && $urandom_range(0, 99) < 17)) begin
          nxt = pending_reqs.pop_front();
          start <= 1'b1;
          req_type <= nxt.req;
          key <= nxt.key;
          value_in <= nxt.val;
          issued++;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every done strobe is matched against the oldest expectation.
  always @(posedge clk) begin
    answer_t e;
    if (!rst && done) begin
      if (expected_answers.size() == 0) begin
        $error("result with no transaction outstanding: status %0d slot %0d", status, slot);
        errors++;
      end else begin
        e = expected_answers.pop_front();
        if (status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, status);
          errors++;
        end
        if (slot !== e.slot) begin
          $error("slot expected %0d actual %0d", e.slot, slot);
          errors++;
        end
        if (value_out !== e.value) begin
          $error("value_out expected %h actual %h", e.value, value_out);
          errors++;
        end
        if (live_count !== e.count) begin
          $error("live_count expected %0d actual %0d", e.count, live_count);
          errors++;
        end
      end
    end
  end

  // Watchdog: the limit covers the post-reset sweep and the slowest transaction,
  // a clear or a probe walk that exhausts the table.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if ((start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push_req(req_t r, logic [63:0] k, logic [63:0] v);
    pending_reqs.push_back('{r, k, v});
    queued++;
  endtask

  // Waits until every transaction has been taken and answered; a request that
  // is still being offered on start counts as outstanding.
  task automatic drain();
    while (issued != queued || pending_reqs.size() != 0 || expected_answers.size() != 0 ||
           busy || start)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == CFG_STORE_VALUES) cur_store = data[0];
    else cur_mode = data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random traffic over a small key pool so that hits, deletes and
  // reinsertion of deleted buckets happen often; high bits vary under masking.
  task automatic random_phase(int n);
    logic [63:0] k;
    int          pick;
    for (int i = 0; i < POOL_N; i++) key_pool[i] = {$urandom, $urandom};
    for (int i = 0; i < n; i++) begin
      k = key_pool[$urandom_range(0, POOL_N - 1)];
      if ($urandom_range(0, 3) == 0) k[63:16] = {$urandom, 16'($urandom)};
      pick = $urandom_range(0, 99);
      if (pick < 3) push_req(REQ_CLEAR, {$urandom, $urandom}, {$urandom, $urandom});
      else if (pick < 45) push_req(REQ_INSERT, k, {$urandom, $urandom});
      else if (pick < 70) push_req(REQ_DELETE, k, {$urandom, $urandom});
      else push_req(REQ_LOOKUP, k, {$urandom, $urandom});
    end
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: extreme keys and values, every request type, overwrite of a
    // present key, delete hit and miss, reuse of a deleted bucket, clear.
    write_reg(CFG_STORE_VALUES, 2'd1);
    write_reg(CFG_KEY_MODE, KM_MIX64);
    push_req(REQ_INSERT, 64'd0, '1);
    push_req(REQ_INSERT, '1, 64'd0);
    push_req(REQ_LOOKUP, 64'd0, 64'd0);
    push_req(REQ_LOOKUP, '1, '1);
    push_req(REQ_INSERT, 64'd0, 64'h0123_4567_89ab_cdef);
    push_req(REQ_LOOKUP, 64'd0, 64'd0);
    push_req(REQ_LOOKUP, 64'h55, 64'd0);
    push_req(REQ_DELETE, 64'h55, 64'd0);
    push_req(REQ_DELETE, 64'd0, 64'd0);
    push_req(REQ_LOOKUP, 64'd0, 64'd0);
    push_req(REQ_INSERT, 64'd0, 64'haa);
    push_req(REQ_LOOKUP, 64'd0, 64'd0);
    push_req(REQ_CLEAR, '1, '1);
    push_req(REQ_LOOKUP, '1, 64'd0);
    push_req(REQ_INSERT, '1, 64'h8000_0000_0000_0001);
    drain();

    // Set mode with 16-bit identity keys.
    write_reg(CFG_STORE_VALUES, 2'd0);
    write_reg(CFG_KEY_MODE, KM_ID16);
    random_phase(250);

    // Fill every bucket with 32-bit identity keys, then hit the full table,
    // reuse deleted buckets after an exhausted walk, and miss on a full walk.
    write_reg(CFG_STORE_VALUES, 2'd1);
    write_reg(CFG_KEY_MODE, KM_ID32);
    push_req(REQ_CLEAR, 64'd0, 64'd0);
    for (int i = 0; i < NBKT; i++) push_req(REQ_INSERT, {32'($urandom), 32'(i)}, {$urandom, $urandom});
    for (int i = 0; i < 4; i++) push_req(REQ_INSERT, 64'd5000 + i, {$urandom, $urandom});
    push_req(REQ_INSERT, {32'hffff_ffff, 32'd17}, 64'd1);
    push_req(REQ_DELETE, 64'd5, 64'd0);
    push_req(REQ_DELETE, 64'd700, 64'd0);
    push_req(REQ_LOOKUP, 64'd7000, 64'd0);
    push_req(REQ_INSERT, 64'd7000, 64'd2);
    push_req(REQ_INSERT, 64'd7001, 64'd3);
    push_req(REQ_INSERT, 64'd7002, 64'd4);
    push_req(REQ_LOOKUP, 64'd7001, 64'd0);
    push_req(REQ_CLEAR, 64'd0, 64'd0);
    drain();

    // Key mode three behaves as the mixed 64-bit hash.
    write_reg(CFG_KEY_MODE, 2'd3);
    random_phase(200);

    write_reg(CFG_STORE_VALUES, 2'd0);
    write_reg(CFG_KEY_MODE, KM_MIX64);
    random_phase(200);

    // A long stretch with back-to-back transactions.
    allow_idle = 1'b0;
    write_reg(CFG_STORE_VALUES, 2'd1);
    write_reg(CFG_KEY_MODE, KM_ID16);
    random_phase(250);

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* open_address_hash_table.f */
hw/rtl/oaht_pkg.sv
hw/rtl/oaht_ram.sv
hw/rtl/oaht_hash.sv
hw/rtl/open_address_hash_table.sv
tb/tb_top.sv
